### rtl/gcdk_pkg.sv
// gcdk_pkg: shared types, constants and cordic/sqrt step functions for the distance pipeline
package gcdk_pkg;

    localparam int LAT_W        = 28;
    localparam int LON_W        = 29;
    localparam int DIST_W       = 15;
    localparam int NLANE        = 4;
    localparam int LAT_LANES    = 2;
    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 31;
    localparam int CV_W         = 34;
    localparam int SQ_W         = 62;

    typedef logic signed [CV_W-1:0] cvec_t;
    typedef logic [SQ_W-1:0] sq_t;

    typedef struct packed {
        cvec_t x;
        cvec_t y;
        cvec_t z;
    } cstate_t;

    typedef struct packed {
        sq_t n;
        sq_t r;
    } sqstate_t;

    localparam logic [63:0] PI_NUM   = 64'd31415927;
    localparam logic [63:0] DIV_FULL = 64'd28125000;
    localparam logic [63:0] DIV_HALF = 64'd56250000;
    localparam logic [63:0] K_FULL   = (PI_NUM << 32) / DIV_FULL;
    localparam logic [63:0] K_HALF   = (PI_NUM << 32) / DIV_HALF;

    localparam cvec_t GAIN_START = 34'sd652032874;

    localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
        30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
        30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
        30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2
    };

    localparam logic [63:0] RADIUS_X2      = 64'd12756274;
    localparam logic [63:0] TENTH_MM_PER_M = 64'd10000;
    localparam logic [63:0] HALF_KM_U      = 64'd5000000;
    localparam logic [63:0] KM_U           = 64'd10000000;
    localparam int          KM_RECIP_SHIFT = 38;
    localparam logic [63:0] KM_RECIP       = (64'd1 << KM_RECIP_SHIFT) / KM_U;

    // one rotation-mode iteration, floor shifts
    function automatic cstate_t rot_step(input cstate_t s, input int i);
        cstate_t o;
        cvec_t   dx;
        cvec_t   dy;
        cvec_t   da;
        dx = s.y >>> i;
        dy = s.x >>> i;
        da = cvec_t'(ATAN_Q30[i]);
        if (!s.z[CV_W-1]) begin
            o.x = s.x - dx;
            o.y = s.y + dy;
            o.z = s.z - da;
        end else begin
            o.x = s.x + dx;
            o.y = s.y - dy;
            o.z = s.z + da;
        end
        return o;
    endfunction

    // one vectoring-mode iteration, floor shifts
    function automatic cstate_t vec_step(input cstate_t s, input int i);
        cstate_t o;
        cvec_t   dx;
        cvec_t   dy;
        cvec_t   da;
        dx = s.y >>> i;
        dy = s.x >>> i;
        da = cvec_t'(ATAN_Q30[i]);
        if (!s.y[CV_W-1]) begin
            o.x = s.x + dx;
            o.y = s.y - dy;
            o.z = s.z + da;
        end else begin
            o.x = s.x - dx;
            o.y = s.y + dy;
            o.z = s.z - da;
        end
        return o;
    endfunction

    // one digit of the restoring square root, trial bit 2^(60-2i)
    function automatic sqstate_t sqrt_step(input sqstate_t s, input int i);
        sqstate_t o;
        sq_t      b;
        sq_t      t;
        b = sq_t'(1) << (60 - 2 * i);
        t = s.r + b;
        if (s.n >= t) begin
            o.n = s.n - t;
            o.r = (s.r >> 1) + b;
        end else begin
            o.n = s.n;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

endpackage

### rtl/great_circle_distance_km_top.sv
// great_circle_distance_km_top: pipelined haversine great-circle distance in kilometres
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  s_      | in        | s_valid / s_ready  | s_lat_a, s_lon_a, s_lat_b, s_lon_b
//  m_      | out       | m_valid / m_ready  | m_distance_km
//
//  one transaction enters per cycle while s_ready is high; a result reaches the output
//  register through the reduction, product, scaling, 30-step cordic and 31-digit sqrt stages
//  reset (aresetn low at a clock edge) clears the valid bits, output and skid flags only
//  the whole pipeline advances together; a result that finds the output register full
//  and not taken parks in a skid register, and only then does s_ready drop
//  s_ready comes back the cycle after the skid register drains
module great_circle_distance_km_top #(
    parameter int ANGLE_FRAC_BITS = 20
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [gcdk_pkg::LAT_W-1:0] s_lat_a,
    input  logic signed [gcdk_pkg::LON_W-1:0] s_lon_a,
    input  logic signed [gcdk_pkg::LAT_W-1:0] s_lat_b,
    input  logic signed [gcdk_pkg::LON_W-1:0] s_lon_b,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [gcdk_pkg::DIST_W-1:0]       m_distance_km
);
    import gcdk_pkg::*;

    // turn constants in degrees scaled by the fraction bits
    localparam logic [63:0] FULL_U    = 64'd360 << ANGLE_FRAC_BITS;
    localparam logic [63:0] RECIP_U   = (64'd1 << 31) / FULL_U;
    localparam logic signed [35:0] FULL_S  = 36'(FULL_U);
    localparam logic signed [35:0] HALF_S  = 36'(64'd180 << ANGLE_FRAC_BITS);
    localparam logic signed [35:0] QUART_S = 36'(64'd90 << ANGLE_FRAC_BITS);
    localparam int RAD_SHIFT = 24 - ANGLE_FRAC_BITS;

    // 8 reduction/radian stages, cordic, 3 product stages, sqrt, 2, sqrt, cordic, 5 scaling
    localparam int NSTAGE = 8 + CORDIC_STEPS + 3 + SQRT_STEPS + 2 + SQRT_STEPS
                          + CORDIC_STEPS + 5;

    logic              en;
    logic [NSTAGE-1:0] vld_reg;

    // output register and skid register
    logic              out_v_reg;
    logic              skid_v_reg;
    logic [DIST_W-1:0] out_d_reg;
    logic [DIST_W-1:0] skid_d_reg;

    // lanes: 0 lat_a and 1 lat_b feed cosines, 2 dlat and 3 dlon feed half-angle sines
    logic signed [30:0] ang_in [NLANE];

    logic        w1_neg_reg  [NLANE];
    logic [29:0] w1_mag_reg  [NLANE];
    logic        w2_neg_reg  [NLANE];
    logic [29:0] w2_mag_reg  [NLANE];
    logic [15:0] w2_q_reg    [NLANE];
    logic        w3_neg_reg  [NLANE];
    logic [29:0] w3_r_reg    [NLANE];
    logic signed [33:0] w4_rc_reg [NLANE];
    logic [31:0] w5_m_reg    [NLANE];
    logic        w5_neg_reg  [NLANE];
    logic        w5_cneg_reg [NLANE];
    logic [57:0] w6_p1_reg   [NLANE];
    logic [65:0] w6_pk_reg   [NLANE];
    logic        w6_neg_reg  [NLANE];
    logic        w6_cneg_reg [NLANE];
    logic [57:0] w7_p1_reg   [NLANE];
    logic [60:0] w7_p2_reg   [NLANE];
    logic [33:0] w7_qe_reg   [NLANE];
    logic        w7_neg_reg  [NLANE];
    logic        w7_cneg_reg [NLANE];
    cvec_t       w8_z_reg    [NLANE];
    logic        w8_cneg_reg [NLANE];

    logic        w1_neg_next [NLANE];
    logic [29:0] w1_mag_next [NLANE];
    logic [15:0] w2_q_next   [NLANE];
    logic [29:0] w3_r_next   [NLANE];
    logic signed [33:0] w4_rc_next [NLANE];
    logic [31:0] w5_m_next   [NLANE];
    logic        w5_neg_next [NLANE];
    logic        w5_cneg_next [NLANE];
    logic [57:0] w6_p1_next  [NLANE];
    logic [65:0] w6_pk_next  [NLANE];
    logic [60:0] w7_p2_next  [NLANE];
    logic [33:0] w7_qe_next  [NLANE];
    cvec_t       w8_z_next   [NLANE];

    // rotation cordic per lane, cosine sign flag rides along
    cstate_t rot_reg  [NLANE][CORDIC_STEPS];
    cstate_t rot_next [NLANE][CORDIC_STEPS];
    logic    rot_n_reg [NLANE][CORDIC_STEPS];

    // haversine term
    logic signed [67:0] m1_p_reg;
    logic signed [67:0] m1_s1_reg;
    logic signed [67:0] m1_s2_reg;
    logic signed [71:0] m2_t_reg;
    logic signed [35:0] m2_s1_reg;
    logic [30:0]        m3_h_reg;
    cvec_t              cos_a;
    cvec_t              cos_b;
    logic signed [35:0] p_q30;
    logic signed [35:0] s2_q30;
    logic signed [37:0] h_sum;
    logic [30:0]        h_next;

    // square roots and the sin term carried past the second one
    sqstate_t    sq1_reg  [SQRT_STEPS];
    sqstate_t    sq1_next [SQRT_STEPS];
    logic [30:0] a1_a_reg;
    logic [61:0] a1_aa_reg;
    logic [30:0] a2_a_reg;
    sq_t         a2_n_reg;
    sqstate_t    sq2_reg  [SQRT_STEPS];
    sqstate_t    sq2_next [SQRT_STEPS];
    logic [30:0] sq2_a_reg [SQRT_STEPS];

    // vectoring cordic for the central half angle
    cstate_t vec_reg  [CORDIC_STEPS];
    cstate_t vec_next [CORDIC_STEPS];
    cstate_t vec_init;

    // metres, 0.1 mm units and kilometres
    logic [55:0]       d1_mq_reg;
    logic [69:0]       d2_mu_reg;
    logic [39:0]       d3_v_reg;
    logic [15:0]       d3_q_reg;
    logic [39:0]       d4_v_reg;
    logic [15:0]       d4_q_reg;
    logic [39:0]       d4_pq_reg;
    logic [DIST_W-1:0] km_reg;
    logic [32:0]       theta_u;
    logic [39:0]       u_next;
    logic [39:0]       v_next;
    logic [15:0]       q_next;
    logic [DIST_W-1:0] km_next;

    // whole pipeline moves unless a result sits in the skid register
    assign en      = !skid_v_reg;
    assign s_ready = en;
    assign m_valid = out_v_reg;
    assign m_distance_km = out_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTAGE-2:0], s_valid};
        end
    end

    // angle reduction and conversion to radians q30
    always_comb begin
        logic [63:0]        prod;
        logic [63:0]        rr;
        logic signed [33:0] rt;
        logic signed [35:0] t;
        logic [35:0]        mg;
        logic [63:0]        dv;
        logic [61:0]        rem;
        logic [33:0]        q;

        ang_in[0] = 31'(s_lat_a);
        ang_in[1] = 31'(s_lat_b);
        ang_in[2] = 31'(s_lat_a) - 31'(s_lat_b);
        ang_in[3] = 31'(s_lon_a) - 31'(s_lon_b);

        for (int l = 0; l < NLANE; l++) begin
            // sign and magnitude
            w1_neg_next[l] = ang_in[l][30];
            w1_mag_next[l] = 30'(ang_in[l][30] ? -ang_in[l] : ang_in[l]);

            // quotient estimate by reciprocal, at most one short
            prod         = 64'(w1_mag_reg[l]) * RECIP_U;
            w2_q_next[l] = 16'(prod >> 31);

            w3_r_next[l] = 30'(64'(w2_mag_reg[l]) - 64'(w2_q_reg[l]) * FULL_U);

            // final correction and truncating remainder sign
            rr = (64'(w3_r_reg[l]) >= FULL_U) ? 64'(w3_r_reg[l]) - FULL_U : 64'(w3_r_reg[l]);
            rt = signed'(34'(rr));
            w4_rc_next[l] = w3_neg_reg[l] ? -rt : rt;

            // into [-180, 180), latitude fold beyond +-90
            t = 36'(w4_rc_reg[l]);
            if (t >= HALF_S) begin
                t = t - FULL_S;
            end else if (t < -HALF_S) begin
                t = t + FULL_S;
            end
            w5_cneg_next[l] = 1'b0;
            if (l < LAT_LANES) begin
                if (t > QUART_S) begin
                    t = t - HALF_S;
                    w5_cneg_next[l] = 1'b1;
                end else if (t < -QUART_S) begin
                    t = t + HALF_S;
                    w5_cneg_next[l] = 1'b1;
                end
            end
            w5_neg_next[l] = t[35];
            mg             = 36'(t[35] ? -t : t);
            w5_m_next[l]   = 32'(mg << RAD_SHIFT);

            // m * pi and its quotient estimate by reciprocal
            w6_p1_next[l] = 58'(64'(w5_m_reg[l]) * PI_NUM);
            w6_pk_next[l] = 66'(w5_m_reg[l]) * 66'((l >= LAT_LANES) ? K_HALF : K_FULL);

            dv = (l >= LAT_LANES) ? DIV_HALF : DIV_FULL;
            w7_qe_next[l] = 34'((w6_pk_reg[l] + (66'd1 << 31)) >> 32);
            w7_p2_next[l] = 61'(w7_qe_next[l]) * 61'(dv);

            // round half up correction, sign back on
            rem = 62'(w7_p1_reg[l]) + 62'(dv >> 1) - 62'(w7_p2_reg[l]);
            q   = (rem >= 62'(dv)) ? w7_qe_reg[l] + 34'd1 : w7_qe_reg[l];
            w8_z_next[l] = w7_neg_reg[l] ? -cvec_t'(q) : cvec_t'(q);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < NLANE; l++) begin
                w1_neg_reg[l]  <= w1_neg_next[l];
                w1_mag_reg[l]  <= w1_mag_next[l];
                w2_neg_reg[l]  <= w1_neg_reg[l];
                w2_mag_reg[l]  <= w1_mag_reg[l];
                w2_q_reg[l]    <= w2_q_next[l];
                w3_neg_reg[l]  <= w2_neg_reg[l];
                w3_r_reg[l]    <= w3_r_next[l];
                w4_rc_reg[l]   <= w4_rc_next[l];
                w5_m_reg[l]    <= w5_m_next[l];
                w5_neg_reg[l]  <= w5_neg_next[l];
                w5_cneg_reg[l] <= w5_cneg_next[l];
                w6_p1_reg[l]   <= w6_p1_next[l];
                w6_pk_reg[l]   <= w6_pk_next[l];
                w6_neg_reg[l]  <= w5_neg_reg[l];
                w6_cneg_reg[l] <= w5_cneg_reg[l];
                w7_p1_reg[l]   <= w6_p1_reg[l];
                w7_p2_reg[l]   <= w7_p2_next[l];
                w7_qe_reg[l]   <= w7_qe_next[l];
                w7_neg_reg[l]  <= w6_neg_reg[l];
                w7_cneg_reg[l] <= w6_cneg_reg[l];
                w8_z_reg[l]    <= w8_z_next[l];
                w8_cneg_reg[l] <= w7_cneg_reg[l];
            end
        end
    end

    // sin/cos, one iteration per stage
    always_comb begin
        cstate_t init;
        for (int l = 0; l < NLANE; l++) begin
            init.x = GAIN_START;
            init.y = '0;
            init.z = w8_z_reg[l];
            rot_next[l][0] = rot_step(init, 0);
            for (int i = 1; i < CORDIC_STEPS; i++) begin
                rot_next[l][i] = rot_step(rot_reg[l][i-1], i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < NLANE; l++) begin
                rot_n_reg[l][0] <= w8_cneg_reg[l];
                for (int i = 0; i < CORDIC_STEPS; i++) begin
                    rot_reg[l][i] <= rot_next[l][i];
                end
                for (int i = 1; i < CORDIC_STEPS; i++) begin
                    rot_n_reg[l][i] <= rot_n_reg[l][i-1];
                end
            end
        end
    end

    // h = sin^2(dlat/2) + cos(lat_a) cos(lat_b) sin^2(dlon/2), clamped to [0, 1]
    always_comb begin
        cos_a = rot_n_reg[0][CORDIC_STEPS-1] ? -rot_reg[0][CORDIC_STEPS-1].x
                                             : rot_reg[0][CORDIC_STEPS-1].x;
        cos_b = rot_n_reg[1][CORDIC_STEPS-1] ? -rot_reg[1][CORDIC_STEPS-1].x
                                             : rot_reg[1][CORDIC_STEPS-1].x;
        p_q30  = 36'(m1_p_reg >>> 30);
        s2_q30 = 36'(m1_s2_reg >>> 30);
        h_sum  = 38'(m2_s1_reg) + 38'(m2_t_reg >>> 30);
        if (h_sum[37]) begin
            h_next = '0;
        end else if (h_sum > 38'sd1073741824) begin
            h_next = 31'd1073741824;
        end else begin
            h_next = 31'(h_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_p_reg  <= 68'(cos_a) * 68'(cos_b);
            m1_s1_reg <= 68'(rot_reg[2][CORDIC_STEPS-1].y) * 68'(rot_reg[2][CORDIC_STEPS-1].y);
            m1_s2_reg <= 68'(rot_reg[3][CORDIC_STEPS-1].y) * 68'(rot_reg[3][CORDIC_STEPS-1].y);
            m2_t_reg  <= 72'(p_q30) * 72'(s2_q30);
            m2_s1_reg <= 36'(m1_s1_reg >>> 30);
            m3_h_reg  <= h_next;
        end
    end

    // a = sqrt(h), c = sqrt(1 - a^2), one root digit per stage
    always_comb begin
        sqstate_t init1;
        sqstate_t init2;
        init1.n = sq_t'({m3_h_reg, 30'd0});
        init1.r = '0;
        init2.n = a2_n_reg;
        init2.r = '0;
        sq1_next[0] = sqrt_step(init1, 0);
        sq2_next[0] = sqrt_step(init2, 0);
        for (int i = 1; i < SQRT_STEPS; i++) begin
            sq1_next[i] = sqrt_step(sq1_reg[i-1], i);
            sq2_next[i] = sqrt_step(sq2_reg[i-1], i);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < SQRT_STEPS; i++) begin
                sq1_reg[i] <= sq1_next[i];
                sq2_reg[i] <= sq2_next[i];
            end
            a1_a_reg     <= 31'(sq1_reg[SQRT_STEPS-1].r);
            a1_aa_reg    <= 62'(31'(sq1_reg[SQRT_STEPS-1].r)) *
                            62'(31'(sq1_reg[SQRT_STEPS-1].r));
            a2_a_reg     <= a1_a_reg;
            a2_n_reg     <= (sq_t'(1) << 60) - sq_t'(a1_aa_reg);
            sq2_a_reg[0] <= a2_a_reg;
            for (int i = 1; i < SQRT_STEPS; i++) begin
                sq2_a_reg[i] <= sq2_a_reg[i-1];
            end
        end
    end

    // central half angle atan2(a, c)
    always_comb begin
        vec_init.x = cvec_t'(sq2_reg[SQRT_STEPS-1].r);
        vec_init.y = cvec_t'(sq2_a_reg[SQRT_STEPS-1]);
        vec_init.z = '0;
        vec_next[0] = vec_step(vec_init, 0);
        for (int i = 1; i < CORDIC_STEPS; i++) begin
            vec_next[i] = vec_step(vec_reg[i-1], i);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                vec_reg[i] <= vec_next[i];
            end
        end
    end

    // distance scaling and rounding to km, divides by reciprocal with one correction
    always_comb begin
        theta_u = vec_reg[CORDIC_STEPS-1].z[CV_W-1] ? '0 : 33'(vec_reg[CORDIC_STEPS-1].z);
        u_next  = 40'((d2_mu_reg + (70'd1 << 29)) >> 30);
        v_next  = u_next + 40'(HALF_KM_U);
        q_next  = 16'((56'(v_next) * 56'(KM_RECIP)) >> KM_RECIP_SHIFT);
        km_next = ((d4_v_reg - d4_pq_reg) >= 40'(KM_U)) ? DIST_W'(d4_q_reg + 16'd1)
                                                       : DIST_W'(d4_q_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_mq_reg <= 56'(theta_u) * 56'(RADIUS_X2);
            d2_mu_reg <= 70'(d1_mq_reg) * 70'(TENTH_MM_PER_M);
            d3_v_reg  <= v_next;
            d3_q_reg  <= q_next;
            d4_v_reg  <= d3_v_reg;
            d4_q_reg  <= d3_q_reg;
            d4_pq_reg <= 40'(d3_q_reg) * 40'(KM_U);
            km_reg    <= km_next;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            if (skid_v_reg) begin
                if (m_ready) begin
                    skid_v_reg <= 1'b0;
                end
            end else if (vld_reg[NSTAGE-1]) begin
                if (out_v_reg && !m_ready) begin
                    skid_v_reg <= 1'b1;
                end else begin
                    out_v_reg <= 1'b1;
                end
            end else if (m_ready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_v_reg) begin
            if (m_ready) begin
                out_d_reg <= skid_d_reg;
            end
        end else if (vld_reg[NSTAGE-1]) begin
            if (out_v_reg && !m_ready) begin
                skid_d_reg <= km_reg;
            end else begin
                out_d_reg <= km_reg;
            end
        end
    end

endmodule

### tb/sv/great_circle_distance_km_top_tb.sv
// great_circle_distance_km_top_tb: directed and random checks of the haversine distance pipeline
`timescale 1ns / 1ps

module great_circle_distance_km_top_tb;
    import gcdk_pkg::*;

    localparam int  FRAC        = 20;
    localparam longint DEG      = 64'sd1 << FRAC;
    localparam int  MAX_GAP     = 8;
    localparam int  DRAIN_WAIT  = 200;
    localparam longint CYCLE_LIMIT = 400000;
    localparam longint LAT_MAX  = 94371840;
    localparam longint LON_MAX  = 188743680;
    localparam longint DIV_FULL_C = 28125000;
    localparam longint DIV_HALF_C = 56250000;
    localparam longint PI_NUM_C   = 31415927;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic signed [LAT_W-1:0] s_lat_a;
    logic signed [LON_W-1:0] s_lon_a;
    logic signed [LAT_W-1:0] s_lat_b;
    logic signed [LON_W-1:0] s_lon_b;
    logic                m_valid;
    logic                m_ready;
    logic [DIST_W-1:0]   m_distance_km;

    // expected distances in order of acceptance
    logic [DIST_W-1:0] km_expected_q[$];
    int     mismatch_count;
    longint cycle_count;
    bit     sender_busy_mode;   // no gaps between transactions when set
    bit     receiver_busy_mode; // never stalls the result channel when set
    bit     result_taken;
    int     stall_left;
    int     stall_draw;

    great_circle_distance_km_top #(.ANGLE_FRAC_BITS(FRAC)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_lat_a(s_lat_a), .s_lon_a(s_lon_a), .s_lat_b(s_lat_b), .s_lon_b(s_lon_b),
        .m_valid(m_valid), .m_ready(m_ready), .m_distance_km(m_distance_km)
    );

    // 20 ns clock
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // ---------------- distance predictor ----------------

    // reduce into [-180, 180) degrees, truncating remainder as in integer division
    function automatic longint wrap_full_turn(input longint d);
        longint full;
        longint r;
        full = 64'sd360 << FRAC;
        r = d % full;
        if (r >= full / 2) r -= full;
        else if (r < -(full / 2)) r += full;
        return r;
    endfunction

    // degrees to radians q30, rounded half up on the magnitude
    function automatic longint degrees_to_q30(input longint d, input longint div);
        longint m;
        m = (d < 0) ? -d : d;
        m = m << (24 - FRAC);
        m = (m * PI_NUM_C + div / 2) / div;
        return (d < 0) ? -m : m;
    endfunction

    function automatic void rotate_angle(input longint z, output longint cv, output longint sv);
        longint x;
        longint y;
        longint dx;
        longint dy;
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
            end
        end
        cv = x;
        sv = y;
    endfunction

    function automatic longint arc_tangent(input longint y, input longint x);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
            end else begin
                x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
            end
        end
        return z;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // cosine of a latitude, folding beyond the poles with a sign flip
    function automatic longint latitude_cos(input longint lat);
        longint r;
        longint q;
        longint c;
        longint s;
        bit     flip;
        r = wrap_full_turn(lat);
        q = 64'sd90 << FRAC;
        flip = 1'b0;
        if (r > q) begin
            r -= 2 * q; flip = 1'b1;
        end else if (r < -q) begin
            r += 2 * q; flip = 1'b1;
        end
        rotate_angle(degrees_to_q30(r, DIV_FULL_C), c, s);
        return flip ? -c : c;
    endfunction

    function automatic longint half_angle_sin_sq(input longint d);
        longint c;
        longint s;
        rotate_angle(degrees_to_q30(wrap_full_turn(d), DIV_HALF_C), c, s);
        return (s * s) >>> 30;
    endfunction

    function automatic logic [DIST_W-1:0] great_circle_km(input longint lat_a, input longint lon_a,
                                                         input longint lat_b, input longint lon_b);
        longint p;
        longint h;
        longint theta;
        longint unsigned a;
        longint unsigned c;
        longint unsigned mq;
        longint unsigned u;
        longint unsigned km;
        p = (latitude_cos(lat_a) * latitude_cos(lat_b)) >>> 30;
        h = half_angle_sin_sq(lat_a - lat_b) + ((p * half_angle_sin_sq(lon_a - lon_b)) >>> 30);
        if (h < 0) h = 0;
        if (h > (64'sd1 << 30)) h = 64'sd1 << 30;
        a = int_sqrt(longint'(h) << 30);
        c = int_sqrt((64'd1 << 60) - a * a);
        theta = arc_tangent(longint'(a), longint'(c));
        if (theta < 0) theta = 0;
        mq = longint'(theta) * 64'd12756274;
        u = (mq >> 30) * 64'd10000 + (((mq & ((64'd1 << 30) - 1)) * 64'd10000 + (64'd1 << 29)) >> 30);
        km = ((u + 64'd5000000) / 64'd10000) / 64'd1000;
        return km[DIST_W-1:0];
    endfunction

    // ---------------- sending ----------------

    // offer one point pair, wait for its acceptance and record the predicted distance
    task automatic send_pair(input longint lat_a, input longint lon_a,
                             input longint lat_b, input longint lon_b);
        int gap;
        bit ok;
        gap = sender_busy_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_lat_a <= lat_a[LAT_W-1:0];
        s_lon_a <= lon_a[LON_W-1:0];
        s_lat_b <= lat_b[LAT_W-1:0];
        s_lon_b <= lon_b[LON_W-1:0];
        // s_ready is steady at the falling edge, so it tells what the next rising edge sees
        do begin
            @(negedge aclk);
            ok = s_ready;
            @(posedge aclk);
        end while (!ok);
        km_expected_q.push_back(great_circle_km(
            longint'($signed(lat_a[LAT_W-1:0])), longint'($signed(lon_a[LON_W-1:0])),
            longint'($signed(lat_b[LAT_W-1:0])), longint'($signed(lon_b[LON_W-1:0]))));
    endtask

    task automatic wait_all_results();
        while (km_expected_q.size() != 0) @(posedge aclk);
    endtask

    function automatic longint rand_range(input longint lim);
        return longint'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // ---------------- result checking ----------------

    // at the falling edge the handshake signals are settled for the coming rising edge
    always @(negedge aclk) begin
        result_taken <= aresetn && m_valid && m_ready;
        if (aresetn && m_valid && m_ready) begin
            if (km_expected_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transaction: distance_km %0d", m_distance_km);
            end else begin
                logic [DIST_W-1:0] want;
                want = km_expected_q.pop_front();
                if (m_distance_km !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("distance_km mismatch: expected %0d, actual %0d",
                                 want, m_distance_km);
                end
            end
        end
    end

    // result channel back-pressure, a fresh random stall drawn after each transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, MAX_GAP);
        end else if (result_taken) begin
            if (receiver_busy_mode) begin
                m_ready <= 1'b1;
            end else begin
                stall_draw = $urandom_range(0, MAX_GAP);
                m_ready    <= (stall_draw == 0);
                stall_left <= (stall_draw == 0) ? 0 : stall_draw - 1;
            end
        end else if (stall_left > 0 && !receiver_busy_mode) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // run watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------- tests ----------------

    // extremes of every field, coincident, antipodal, polar and out-of-range points
    task automatic test_directed();
        send_pair(0, 0, 0, 0);
        send_pair(45 * DEG, 100 * DEG, 45 * DEG, 100 * DEG);
        send_pair(0, 0, 0, 180 * DEG);
        send_pair(0, -180 * DEG, 0, 0);
        send_pair(90 * DEG, 0, -90 * DEG, 0);
        send_pair(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX);
        send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
        send_pair((1 <<< 27) - 1, (1 <<< 28) - 1, -(1 <<< 27), -(1 <<< 28));
        send_pair(-(1 <<< 27), -(1 <<< 28), (1 <<< 27) - 1, (1 <<< 28) - 1);
        send_pair(135 * DEG, 0, 45 * DEG, 180 * DEG);
        send_pair(-120 * DEG, 270 * DEG, 10 * DEG, -270 * DEG);
        send_pair(30 * DEG, 20 * DEG, -30 * DEG, -160 * DEG);
        send_pair(1, 0, 0, 0);
        send_pair(0, 1, 0, 0);
        send_pair(51 * DEG, 0, 40 * DEG, -74 * DEG);
        send_pair(-33 * DEG, 151 * DEG, 35 * DEG, 139 * DEG);
        send_pair(89 * DEG, 179 * DEG, -89 * DEG, -1 * DEG);
        send_pair(0, 0, 0, 1 * DEG);
    endtask

    // mostly valid coordinates, some raw full-width words and nearly coincident pairs
    task automatic test_random(input int count);
        longint la;
        longint oa;
        longint lb;
        longint ob;
        int     kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                la = rand_range(LAT_MAX); oa = rand_range(LON_MAX);
                lb = rand_range(LAT_MAX); ob = rand_range(LON_MAX);
            end else if (kind < 9) begin
                la = longint'($signed(LAT_W'($urandom)));
                oa = longint'($signed(LON_W'($urandom)));
                lb = longint'($signed(LAT_W'($urandom)));
                ob = longint'($signed(LON_W'($urandom)));
            end else begin
                la = rand_range(LAT_MAX); oa = rand_range(LON_MAX);
                lb = la + rand_range(4096); ob = oa + rand_range(4096);
            end
            send_pair(la, oa, lb, ob);
        end
    endtask

    // back-to-back with no stalls; the sender then holds off until all results return, then sends more
    task automatic test_full_rate_then_drain();
        sender_busy_mode   = 1'b1;
        receiver_busy_mode = 1'b1;
        test_random(150);
        sender_busy_mode   = 1'b0;
        receiver_busy_mode = 1'b0;
        s_valid <= 1'b0;
        wait_all_results();
        test_random(50);
    endtask

    initial begin
        mismatch_count     = 0;
        cycle_count        = 0;
        sender_busy_mode   = 1'b0;
        receiver_busy_mode = 1'b0;
        result_taken       = 1'b0;
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_lat_a            = '0;
        s_lon_a            = '0;
        s_lat_b            = '0;
        s_lon_b            = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(450);
        test_full_rate_then_drain();
        test_random(480);

        s_valid <= 1'b0;
        wait_all_results();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0 && km_expected_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/gcdk_pkg.sv
rtl/great_circle_distance_km_top.sv
tb/sv/great_circle_distance_km_top_tb.sv
